// ----- sv/rfid_tag_access_checker_assert.svh -----
// Assertion macros for the tag access checker
`ifndef RFID_TAG_ACCESS_CHECKER_ASSERT_SVH
`define RFID_TAG_ACCESS_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
`define RTAC_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("rtac assertion failed");
`define RTAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtac assertion failed");
`else
`define RTAC_ASSERT(label, expr)
`define RTAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/rtac_pkg.sv -----
// Shared types, constants and functions of the tag access checker
`timescale 1ns / 1ps

package rtac_pkg;

    localparam int NUM_ENTRIES = 5;
    localparam int ID_CHARS    = 8;
    localparam int LEVEL_W     = 2;
    localparam int LEVELS_W    = NUM_ENTRIES * LEVEL_W;
    localparam int INDEX_W     = 3;
    localparam int SWITCH_W    = 18;

    localparam logic [7:0]          RESTART_CHAR = 8'h2E;
    localparam logic [7:0]          GREEN_ON     = 8'hFF;
    localparam logic [SWITCH_W-1:0] RED_ON       = 18'h3FFFF;
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 10'd991;

    localparam logic [INDEX_W-1:0] CFG_TAG_ZERO    = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_ENTRY_LEVELS = 3'd5;

    typedef logic [31:0] t_tag_array [NUM_ENTRIES];

    localparam t_tag_array TAG_RESET = '{
        32'h372F64F0, 32'hA70B64F0, 32'hE71EB654, 32'h876EA2FD, 32'h278F63F0
    };

    typedef struct packed {
        logic [31:0]         seg_high_word;
        logic [31:0]         seg_low_word;
        logic                known_tag;
        logic [INDEX_W-1:0]  entry_index;
        logic                granted;
        logic [7:0]          green_leds;
        logic [SWITCH_W-1:0] red_leds;
    } t_result;

    function automatic logic [3:0] char_to_nibble(input logic [7:0] c);
        logic [3:0] d;
        if (c < 8'd65) begin
            d = c[3:0];
        end else begin
            d = c[3:0] - 4'd7;
        end
        return d;
    endfunction

    function automatic logic is_upper_hex(input logic [7:0] c);
        return ((c >= 8'd48) && (c <= 8'd57)) || ((c >= 8'd65) && (c <= 8'd70));
    endfunction

    function automatic logic [6:0] seg_code(input logic [3:0] n);
        logic [6:0] s;
        unique case (n)
            4'h0: s = 7'h3F;
            4'h1: s = 7'h06;
            4'h2: s = 7'h5B;
            4'h3: s = 7'h4F;
            4'h4: s = 7'h66;
            4'h5: s = 7'h6D;
            4'h6: s = 7'h7D;
            4'h7: s = 7'h07;
            4'h8: s = 7'h7F;
            4'h9: s = 7'h6F;
            4'hA: s = 7'h77;
            4'hB: s = 7'h7C;
            4'hC: s = 7'h39;
            4'hD: s = 7'h5E;
            4'hE: s = 7'h79;
            default: s = 7'h71;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] seg_word(input logic [15:0] half);
        logic [31:0] w;
        w = {1'b0, seg_code(half[15:12]), 1'b0, seg_code(half[11:8]),
             1'b0, seg_code(half[7:4]),   1'b0, seg_code(half[3:0])};
        return ~w;
    endfunction

endpackage

// ----- sv/rtac_decide.sv -----
// Tag table compare, level check and display word generation
`timescale 1ns / 1ps

module rtac_decide (
    input  logic [31:0]                     i_id,
    input  logic                            i_nonhex,
    input  rtac_pkg::t_tag_array            i_tags,
    input  logic [rtac_pkg::LEVELS_W-1:0]   i_levels,
    input  logic [rtac_pkg::SWITCH_W-1:0]   i_switch_level,
    output rtac_pkg::t_result               o_result
);

    logic                           known;
    logic [rtac_pkg::INDEX_W-1:0]   idx;
    logic [rtac_pkg::LEVEL_W-1:0]   lvl;
    logic                           grant;

    // lowest matching entry wins
    always_comb begin
        known = 1'b0;
        idx   = '0;
        for (int n = rtac_pkg::NUM_ENTRIES - 1; n >= 0; n--) begin
            if (!i_nonhex && (i_tags[n] == i_id)) begin
                known = 1'b1;
                idx   = rtac_pkg::INDEX_W'(n);
            end
        end
    end

    assign lvl   = rtac_pkg::LEVEL_W'(i_levels >> {idx, 1'b0});
    assign grant = known && ({{(rtac_pkg::SWITCH_W - rtac_pkg::LEVEL_W){1'b0}}, lvl}
                             >= i_switch_level);

    always_comb begin
        o_result.seg_high_word = rtac_pkg::seg_word(i_id[31:16]);
        o_result.seg_low_word  = rtac_pkg::seg_word(i_id[15:0]);
        o_result.known_tag     = known;
        o_result.entry_index   = idx;
        o_result.granted       = grant;
        o_result.green_leds    = grant ? rtac_pkg::GREEN_ON : '0;
        o_result.red_leds      = grant ? '0 : rtac_pkg::RED_ON;
    end

endmodule

// ----- sv/rfid_tag_access_checker.sv -----
// Top level of the RFID tag access checker
// o_out_valid rises after the eighth ID character has passed the input register and then the
// result register; the result stays there until it is taken with i_out_ready high.
// Throughput: one character per cycle unless a result is held; the five tag compares run in parallel.
// A result held by i_out_ready low stalls the completing character and the input behind it.
// Synchronous active-low reset clears collection state and loads the default tags/levels.
`timescale 1ns / 1ps

`include "rfid_tag_access_checker_assert.svh"

module rfid_tag_access_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rtac_pkg::INDEX_W-1:0]    i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_rx_byte,
    input  logic [rtac_pkg::SWITCH_W-1:0]   i_switch_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [31:0]                     o_seg_high_word,
    output logic [31:0]                     o_seg_low_word,
    output logic                            o_known_tag,
    output logic [rtac_pkg::INDEX_W-1:0]    o_entry_index,
    output logic                            o_granted,
    output logic [7:0]                      o_green_leds,
    output logic [rtac_pkg::SWITCH_W-1:0]   o_red_leds
);

    localparam logic [2:0] LAST_CHAR = 3'(rtac_pkg::ID_CHARS - 1);

    rtac_pkg::t_tag_array           r_tags;
    logic [rtac_pkg::LEVELS_W-1:0]  r_levels;

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic [rtac_pkg::SWITCH_W-1:0]  r_in_switch;

    logic [2:0]                     r_count;
    logic [31:0]                    r_id;
    logic                           r_nonhex;

    logic                           r_out_valid;
    rtac_pkg::t_result              r_result;

    logic                           w_restart;
    logic                           w_complete;
    logic                           w_out_free;
    logic                           w_fire;
    logic [31:0]                    n_id;
    logic                           n_nonhex;
    rtac_pkg::t_result              w_result;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags   <= rtac_pkg::TAG_RESET;
            r_levels <= rtac_pkg::LEVELS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index < rtac_pkg::CFG_ENTRY_LEVELS) begin
                r_tags[i_cfg_index - rtac_pkg::CFG_TAG_ZERO] <= i_cfg_data;
            end else if (i_cfg_index == rtac_pkg::CFG_ENTRY_LEVELS) begin
                r_levels <= i_cfg_data[rtac_pkg::LEVELS_W-1:0];
            end
        end
    end

    assign w_restart  = (r_in_byte == rtac_pkg::RESTART_CHAR);
    assign w_complete = !w_restart && (r_count == LAST_CHAR);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && (!w_complete || w_out_free);
    assign o_in_ready = !r_in_valid || w_fire;

    assign n_id     = {r_id[27:0], rtac_pkg::char_to_nibble(r_in_byte)};
    assign n_nonhex = r_nonhex || !rtac_pkg::is_upper_hex(r_in_byte);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte   <= i_rx_byte;
            r_in_switch <= i_switch_level;
        end
    end

    // ID collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_id     <= '0;
            r_nonhex <= 1'b0;
        end else if (w_fire) begin
            if (w_restart) begin
                r_count  <= '0;
                r_nonhex <= 1'b0;
            end else if (w_complete) begin
                r_count  <= '0;
                r_id     <= n_id;
                r_nonhex <= 1'b0;
            end else begin
                r_count  <= r_count + 3'd1;
                r_id     <= n_id;
                r_nonhex <= n_nonhex;
            end
        end
    end

    rtac_decide u_decide (
        .i_id           (n_id),
        .i_nonhex       (n_nonhex),
        .i_tags         (r_tags),
        .i_levels       (r_levels),
        .i_switch_level (r_in_switch),
        .o_result       (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_complete) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_complete) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_seg_high_word = r_result.seg_high_word;
    assign o_seg_low_word  = r_result.seg_low_word;
    assign o_known_tag     = r_result.known_tag;
    assign o_entry_index   = r_result.entry_index;
    assign o_granted       = r_result.granted;
    assign o_green_leds    = r_result.green_leds;
    assign o_red_leds      = r_result.red_leds;

    `RTAC_ASSERT(a_grant_needs_known, !r_out_valid || !r_result.granted || r_result.known_tag)
    `RTAC_ASSERT(a_index_zero_unknown, !r_out_valid || r_result.known_tag || (r_result.entry_index == '0))
    `RTAC_ASSERT_NEXT(a_complete_clears, w_fire && w_complete, (r_count == '0) && !r_nonhex && r_out_valid)
    `RTAC_ASSERT_NEXT(a_restart_clears, w_fire && w_restart, (r_count == '0) && !r_nonhex)

endmodule
